// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)

`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

// ===== design/ckb_pkg.sv =====
// ----------------------------------------------------------------------------
// ckb_pkg
// types, constants and color expansion tables of the color key blitter
// ----------------------------------------------------------------------------
package ckb_pkg;

	localparam int COORD_BITS    = 12;
	localparam int POS_BITS      = COORD_BITS + 1;
	localparam int PIXEL_BITS    = 16;
	localparam int FW_BITS       = 13;
	localparam int OFFSET_BITS   = 25;
	localparam int RGB_BITS      = 24;
	localparam int OUT_BITS      = OFFSET_BITS + RGB_BITS;
	localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 13;
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

	localparam logic [PIXEL_BITS-1:0] TRANSPARENT = 16'h0000;

	localparam logic [FW_BITS-1:0]    FRAME_WIDTH_RST  = 13'd1024;
	localparam logic [COORD_BITS-1:0] DEST_X_RST       = '0;
	localparam logic [COORD_BITS-1:0] DEST_Y_RST       = '0;
	localparam logic [COORD_BITS-1:0] IMAGE_WIDTH_RST  = COORD_BITS'(15);
	localparam logic [COORD_BITS-1:0] IMAGE_HEIGHT_RST = COORD_BITS'(25);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_DEST_X       = 3'd1,
		REG_DEST_Y       = 3'd2,
		REG_IMAGE_WIDTH  = 3'd3,
		REG_IMAGE_HEIGHT = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] pixel;
		logic [POS_BITS-1:0]   pos_y;
		logic [POS_BITS-1:0]   pos_x;
	} job_t;

	typedef struct packed {
		logic push;
		job_t job;
	} fifo_wr_t;

	typedef struct packed {
		logic avail;
		job_t job;
	} fifo_rd_t;

	function automatic logic [7:0] widen5(input logic [4:0] c);
		logic [7:0] v;
		case (c)
			5'd0:  v = 8'd0;
			5'd1:  v = 8'd8;
			5'd2:  v = 8'd16;
			5'd3:  v = 8'd24;
			5'd4:  v = 8'd32;
			5'd5:  v = 8'd41;
			5'd6:  v = 8'd49;
			5'd7:  v = 8'd57;
			5'd8:  v = 8'd65;
			5'd9:  v = 8'd74;
			5'd10: v = 8'd82;
			5'd11: v = 8'd90;
			5'd12: v = 8'd98;
			5'd13: v = 8'd106;
			5'd14: v = 8'd115;
			5'd15: v = 8'd123;
			5'd16: v = 8'd131;
			5'd17: v = 8'd139;
			5'd18: v = 8'd148;
			5'd19: v = 8'd156;
			5'd20: v = 8'd164;
			5'd21: v = 8'd172;
			5'd22: v = 8'd180;
			5'd23: v = 8'd189;
			5'd24: v = 8'd197;
			5'd25: v = 8'd205;
			5'd26: v = 8'd213;
			5'd27: v = 8'd222;
			5'd28: v = 8'd230;
			5'd29: v = 8'd238;
			5'd30: v = 8'd246;
			default: v = 8'd255;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] widen6(input logic [5:0] c);
		logic [7:0] v;
		case (c)
			6'd0:  v = 8'd0;
			6'd1:  v = 8'd4;
			6'd2:  v = 8'd8;
			6'd3:  v = 8'd12;
			6'd4:  v = 8'd16;
			6'd5:  v = 8'd20;
			6'd6:  v = 8'd24;
			6'd7:  v = 8'd28;
			6'd8:  v = 8'd32;
			6'd9:  v = 8'd36;
			6'd10: v = 8'd40;
			6'd11: v = 8'd44;
			6'd12: v = 8'd48;
			6'd13: v = 8'd52;
			6'd14: v = 8'd56;
			6'd15: v = 8'd60;
			6'd16: v = 8'd64;
			6'd17: v = 8'd68;
			6'd18: v = 8'd72;
			6'd19: v = 8'd76;
			6'd20: v = 8'd80;
			6'd21: v = 8'd85;
			6'd22: v = 8'd89;
			6'd23: v = 8'd93;
			6'd24: v = 8'd97;
			6'd25: v = 8'd101;
			6'd26: v = 8'd105;
			6'd27: v = 8'd109;
			6'd28: v = 8'd113;
			6'd29: v = 8'd117;
			6'd30: v = 8'd121;
			6'd31: v = 8'd125;
			6'd32: v = 8'd129;
			6'd33: v = 8'd133;
			6'd34: v = 8'd137;
			6'd35: v = 8'd141;
			6'd36: v = 8'd145;
			6'd37: v = 8'd149;
			6'd38: v = 8'd153;
			6'd39: v = 8'd157;
			6'd40: v = 8'd161;
			6'd41: v = 8'd165;
			6'd42: v = 8'd170;
			6'd43: v = 8'd174;
			6'd44: v = 8'd178;
			6'd45: v = 8'd182;
			6'd46: v = 8'd186;
			6'd47: v = 8'd190;
			6'd48: v = 8'd194;
			6'd49: v = 8'd198;
			6'd50: v = 8'd202;
			6'd51: v = 8'd206;
			6'd52: v = 8'd210;
			6'd53: v = 8'd214;
			6'd54: v = 8'd218;
			6'd55: v = 8'd222;
			6'd56: v = 8'd226;
			6'd57: v = 8'd230;
			6'd58: v = 8'd234;
			6'd59: v = 8'd238;
			6'd60: v = 8'd242;
			6'd61: v = 8'd246;
			6'd62: v = 8'd250;
			default: v = 8'd255;
		endcase
		return v;
	endfunction

endpackage

// ===== design/rgb565_color_key_blitter_core.sv =====
// ----------------------------------------------------------------------------
// rgb565_color_key_blitter_core
// color keyed rgb565 to rgb888 blit with framebuffer offset generation
// ----------------------------------------------------------------------------
// channel   direction  transaction
// s_axis    in         one rgb565 source pixel, raster order
// m_axis    out        one opaque pixel: frame offset and rgb888 value
// cfg       in         one register write, no read-back
//
// one pixel accepted per cycle while the job queue has room; an opaque pixel leaves
// through the queue write, the offset multiply stage and the add stage
// s_axis_tready drops only when the four-entry job queue is full
// a stalled m_axis holds the back pipeline while the front keeps filling the queue
// reset clears the counters, the queue and the registers to their defaults
// ----------------------------------------------------------------------------
module rgb565_color_key_blitter_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ckb_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [ckb_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// source_pixel
	input  logic [ckb_pkg::PIXEL_BITS-1:0]       s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// frame_offset [24:0], pixel_rgb [48:25], zero pad
	output logic [ckb_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata
);

	logic [ckb_pkg::FW_BITS-1:0]    frame_width_q;
	logic [ckb_pkg::COORD_BITS-1:0] dest_x_q;
	logic [ckb_pkg::COORD_BITS-1:0] dest_y_q;
	logic [ckb_pkg::COORD_BITS-1:0] image_width_q;
	logic [ckb_pkg::COORD_BITS-1:0] image_height_q;

	ckb_pkg::fifo_wr_t wr;
	ckb_pkg::fifo_rd_t rd;
	logic              fifo_full;
	logic              pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= ckb_pkg::FRAME_WIDTH_RST;
			dest_x_q       <= ckb_pkg::DEST_X_RST;
			dest_y_q       <= ckb_pkg::DEST_Y_RST;
			image_width_q  <= ckb_pkg::IMAGE_WIDTH_RST;
			image_height_q <= ckb_pkg::IMAGE_HEIGHT_RST;
		end else if (cfg_we) begin
			case (ckb_pkg::reg_idx_t'(cfg_index))
				ckb_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				ckb_pkg::REG_DEST_X:       dest_x_q       <= cfg_data[ckb_pkg::COORD_BITS-1:0];
				ckb_pkg::REG_DEST_Y:       dest_y_q       <= cfg_data[ckb_pkg::COORD_BITS-1:0];
				ckb_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[ckb_pkg::COORD_BITS-1:0];
				ckb_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_data[ckb_pkg::COORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	ckb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.dest_x        (dest_x_q),
		.dest_y        (dest_y_q),
		.image_width   (image_width_q),
		.image_height  (image_height_q),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.fifo_full     (fifo_full),
		.wr            (wr)
	);

	ckb_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.full   (fifo_full),
		.pop    (pop),
		.rd     (rd)
	);

	ckb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.frame_width   (frame_width_q),
		.rd            (rd),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// ===== design/ckb_front.sv =====
// ----------------------------------------------------------------------------
// ckb_front
// accepts source pixels, tracks the raster position and queues opaque pixels
// ----------------------------------------------------------------------------
module ckb_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [ckb_pkg::COORD_BITS-1:0]   dest_x,
	input  logic [ckb_pkg::COORD_BITS-1:0]   dest_y,
	input  logic [ckb_pkg::COORD_BITS-1:0]   image_width,
	input  logic [ckb_pkg::COORD_BITS-1:0]   image_height,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [ckb_pkg::PIXEL_BITS-1:0]   s_axis_tdata,
	input  logic                             fifo_full,
	output ckb_pkg::fifo_wr_t                wr
);

	logic [ckb_pkg::COORD_BITS-1:0] col_q;
	logic [ckb_pkg::COORD_BITS-1:0] row_q;
	logic [ckb_pkg::POS_BITS-1:0]   col_inc;
	logic [ckb_pkg::POS_BITS-1:0]   row_inc;
	logic                           accept;
	logic                           col_wrap;
	logic                           row_wrap;

	assign s_axis_tready = !fifo_full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign col_inc  = {1'b0, col_q} + ckb_pkg::POS_BITS'(1);
	assign row_inc  = {1'b0, row_q} + ckb_pkg::POS_BITS'(1);
	assign col_wrap = col_inc >= {1'b0, image_width};
	assign row_wrap = row_inc >= {1'b0, image_height};

	assign wr.push      = accept && (s_axis_tdata != ckb_pkg::TRANSPARENT);
	assign wr.job.pixel = s_axis_tdata;
	assign wr.job.pos_x = {1'b0, dest_x} + {1'b0, col_q};
	assign wr.job.pos_y = {1'b0, dest_y} + {1'b0, row_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				if (row_wrap) begin
					row_q <= '0;
				end else begin
					row_q <= row_inc[ckb_pkg::COORD_BITS-1:0];
				end
			end else begin
				col_q <= col_inc[ckb_pkg::COORD_BITS-1:0];
			end
		end
	end

endmodule

// ===== design/ckb_fifo.sv =====
// ----------------------------------------------------------------------------
// ckb_fifo
// short job queue between the front and the back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ckb_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  ckb_pkg::fifo_wr_t wr,
	output logic              full,
	input  logic              pop,
	output ckb_pkg::fifo_rd_t rd
);

	ckb_pkg::job_t                     mem_q [ckb_pkg::FIFO_DEPTH];
	logic [ckb_pkg::FIFO_PTR_BITS-1:0] wr_ptr_q;
	logic [ckb_pkg::FIFO_PTR_BITS-1:0] rd_ptr_q;
	logic [ckb_pkg::FIFO_CNT_BITS-1:0] count_q;

	assign full     = count_q == ckb_pkg::FIFO_CNT_BITS'(ckb_pkg::FIFO_DEPTH);
	assign rd.avail = count_q != '0;
	assign rd.job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr.push) begin
			mem_q[wr_ptr_q] <= wr.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.push) begin
				wr_ptr_q <= wr_ptr_q + ckb_pkg::FIFO_PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + ckb_pkg::FIFO_PTR_BITS'(1);
			end
			case ({wr.push, pop})
				2'b10:   count_q <= count_q + ckb_pkg::FIFO_CNT_BITS'(1);
				2'b01:   count_q <= count_q - ckb_pkg::FIFO_CNT_BITS'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_NEVER(a_push_full, clk, arst_n, wr.push && full, "push into full queue")
	`ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && !rd.avail, "pop from empty queue")
	`ASSERT_PROP(a_count_up, clk, arst_n, (wr.push && !pop) |=> (count_q == $past(count_q) + ckb_pkg::FIFO_CNT_BITS'(1)), "queue count lost a push")

endmodule

// ===== design/ckb_back.sv =====
// ----------------------------------------------------------------------------
// ckb_back
// expands queued pixels to rgb888 and computes the framebuffer offset
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ckb_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [ckb_pkg::FW_BITS-1:0]          frame_width,
	input  ckb_pkg::fifo_rd_t                    rd,
	output logic                                 pop,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [ckb_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata
);

	localparam int PROD_BITS = ckb_pkg::POS_BITS + ckb_pkg::FW_BITS;

	logic                               en;
	logic [PROD_BITS-1:0]               prod_full;
	logic [ckb_pkg::RGB_BITS-1:0]       rgb;
	logic                               vld_s1;
	logic [ckb_pkg::OFFSET_BITS-1:0]    prod_s1;
	logic [ckb_pkg::POS_BITS-1:0]       x_s1;
	logic [ckb_pkg::RGB_BITS-1:0]       rgb_s1;
	logic                               vld_s2;
	logic [ckb_pkg::OFFSET_BITS-1:0]    off_s2;
	logic [ckb_pkg::RGB_BITS-1:0]       rgb_s2;

	assign en  = !vld_s2 || m_axis_tready;
	assign pop = en && rd.avail;

	assign prod_full = PROD_BITS'(rd.job.pos_y) * PROD_BITS'(frame_width);
	assign rgb = {ckb_pkg::widen5(rd.job.pixel[15:11]),
		ckb_pkg::widen6(rd.job.pixel[10:5]),
		ckb_pkg::widen5(rd.job.pixel[4:0])};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= rd.avail;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod_full[ckb_pkg::OFFSET_BITS-1:0];
			x_s1    <= rd.job.pos_x;
			rgb_s1  <= rgb;
			off_s2  <= prod_s1 + ckb_pkg::OFFSET_BITS'(x_s1);
			rgb_s2  <= rgb_s1;
		end
	end

	assign m_axis_tvalid = vld_s2;
	// rgb888 pixel above frame offset, zero padded
	assign m_axis_tdata  = {{(ckb_pkg::OUT_TDATA_BITS - ckb_pkg::OUT_BITS){1'b0}},
		rgb_s2, off_s2};

	`ASSERT_PROP(a_hold_s1, clk, arst_n, !en |=> $stable(vld_s1), "stage one moved during stall")
	`ASSERT_PROP(a_fill_s1, clk, arst_n, pop |=> vld_s1, "popped job did not enter stage one")

endmodule
